// ----- src/per_class_median_selector_assert.svh -----
// Assertion macros used by the per-class median selector controller.
// Expects signals named clk and rst_n in the including module.
`ifndef PER_CLASS_MEDIAN_SELECTOR_ASSERT_SVH
`define PER_CLASS_MEDIAN_SELECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PCMS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcms assertion failed");
`define PCMS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcms assertion failed");
`else
`define PCMS_ASSERT_IMP(label, ante, cons)
`define PCMS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/pcms_pkg.sv -----
// Package for the per-class median selector: sizes, class codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package pcms_pkg;
  localparam int MAX_SAMPLES = 4096;
  localparam int NUM_CLASSES = 3;
  localparam int SMP_W = 24;
  localparam int CLS_W = 2;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int BIT_W = $clog2(SMP_W);
  localparam int ADDR_W = CLS_W + IDX_W;
  localparam int MEM_DEPTH = NUM_CLASSES * MAX_SAMPLES;

  localparam logic [CLS_W-1:0] CLS_AUTO = 2'd0;
  localparam logic [CLS_W-1:0] CLS_LAST = 2'd2;

  typedef struct packed {
    logic load;
    logic first;
    logic start;
    logic scan_issue;
    logic bit_step;
    logic next_class;
    logic clear;
  } pcms_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_end;
    logic bit_zero;
    logic cls_last;
  } pcms_stat_t;
endpackage

// ----- src/pcms_if.sv -----
// Valid/ready channel interfaces for sample words and median result words.
// Depends on pcms_pkg for field widths.
`timescale 1ns / 1ps
interface pcms_in_if;
  logic valid;
  logic ready;
  logic [pcms_pkg::CLS_W-1:0] region_class;
  logic [pcms_pkg::SMP_W-1:0] ratio_sample;
  logic last_sample;
  modport source (output valid, region_class, ratio_sample, last_sample, input ready);
  modport sink (input valid, region_class, ratio_sample, last_sample, output ready);
endinterface

interface pcms_out_if;
  logic valid;
  logic ready;
  logic [pcms_pkg::CLS_W-1:0] out_class;
  logic [pcms_pkg::SMP_W-1:0] median_value;
  logic class_empty;
  logic overflow_seen;
  logic last_result;
  modport source (output valid, out_class, median_value, class_empty, overflow_seen,
                  last_result, input ready);
  modport sink (input valid, out_class, median_value, class_empty, overflow_seen,
                last_result, output ready);
endinterface

// ----- src/pcms_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pcms_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ----- src/pcms_datapath.sv -----
// Datapath: per-class counters, overflow flags, sample RAM and the bitwise
// radix selection registers. Depends on pcms_pkg and pcms_ram.
`timescale 1ns / 1ps
module pcms_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pcms_pkg::pcms_cmd_t         cmd,
  output pcms_pkg::pcms_stat_t        st,
  input  logic [pcms_pkg::CLS_W-1:0]  in_cls,
  input  logic [pcms_pkg::SMP_W-1:0]  in_smp,
  output logic [pcms_pkg::CLS_W-1:0]  res_cls,
  output logic [pcms_pkg::SMP_W-1:0]  res_median,
  output logic                        res_empty,
  output logic                        res_ovf
);
  import pcms_pkg::*;

  logic [CNT_W-1:0] counts_r [NUM_CLASSES];
  logic [CNT_W-1:0] counts_nxt [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] ovf_r, ovf_nxt;
  logic [CLS_W-1:0] cls_r;
  logic [CNT_W-1:0] k_r, cnt_r;
  logic [SMP_W-1:0] prefix_r;
  logic [BIT_W-1:0] bit_r;
  logic [IDX_W-1:0] idx_r;
  logic rd_vld_r;
  logic in_valid_cls, wr_en, match;
  logic [CNT_W-1:0] in_cnt, cur_n, n_m1;
  logic [SMP_W-1:0] rd_data, hi_mask;

  assign in_valid_cls = (in_cls <= CLS_LAST);
  assign in_cnt = in_valid_cls ? counts_r[in_cls] : '0;
  assign wr_en = cmd.load && in_valid_cls && (in_cnt < CNT_W'(MAX_SAMPLES));

  always_comb begin
    counts_nxt = counts_r;
    ovf_nxt = ovf_r;
    if (cmd.clear) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        counts_nxt[c] = '0;
      end
      ovf_nxt = '0;
    end else if (cmd.load && in_valid_cls) begin
      if (wr_en) begin
        counts_nxt[in_cls] = in_cnt + 1'b1;
      end else begin
        ovf_nxt[in_cls] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        counts_r[c] <= '0;
      end
      ovf_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      counts_r <= counts_nxt;
      ovf_r <= ovf_nxt;
      rd_vld_r <= cmd.scan_issue;
    end
  end

  pcms_ram #(
    .WIDTH (SMP_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({in_cls, in_cnt[IDX_W-1:0]}),
    .wr_data (in_smp),
    .rd_en   (cmd.scan_issue),
    .rd_addr ({cls_r, idx_r}),
    .rd_data (rd_data)
  );

  assign cur_n = counts_r[cls_r];
  assign n_m1 = cur_n - 1'b1;
  assign hi_mask = ({SMP_W{1'b1}} << bit_r) << 1;
  assign match = (((rd_data ^ prefix_r) & hi_mask) == '0) && !rd_data[bit_r];

  // Radix select: per bit, count the survivors with a zero at that bit.
  always_ff @(posedge clk) begin
    if (cmd.first) begin
      cls_r <= CLS_AUTO;
    end else if (cmd.next_class) begin
      cls_r <= cls_r + 1'b1;
    end
    if (cmd.start) begin
      k_r <= cur_n >> 1;
      prefix_r <= '0;
      bit_r <= BIT_W'(SMP_W - 1);
      cnt_r <= '0;
      idx_r <= '0;
    end else if (cmd.bit_step) begin
      if (k_r >= cnt_r) begin
        prefix_r[bit_r] <= 1'b1;
        k_r <= k_r - cnt_r;
      end
      cnt_r <= '0;
      idx_r <= '0;
      if (bit_r != '0) begin
        bit_r <= bit_r - 1'b1;
      end
    end else begin
      if (cmd.scan_issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (rd_vld_r && match) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign st.empty = (cur_n == '0);
  assign st.scan_end = (idx_r == n_m1[IDX_W-1:0]);
  assign st.bit_zero = (bit_r == '0);
  assign st.cls_last = (cls_r == CLS_LAST);

  assign res_cls = cls_r;
  assign res_median = prefix_r;
  assign res_empty = st.empty;
  assign res_ovf = ovf_r[cls_r];
endmodule

// ----- src/pcms_ctrl.sv -----
// Controller state machine: load, per-bit scans, and result hand-off.
// Depends on pcms_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "per_class_median_selector_assert.svh"
module pcms_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pcms_pkg::pcms_cmd_t   cmd,
  input  pcms_pkg::pcms_stat_t  st
);
  import pcms_pkg::*;

  typedef enum logic [2:0] {S_LOAD, S_START, S_SCAN, S_DRAIN, S_STEP, S_EMIT} state_t;
  state_t state_r, state_nxt;
  logic in_fire, out_fire;

  assign in_ready = (state_r == S_LOAD);
  assign out_valid = (state_r == S_EMIT);
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        cmd.load = in_fire;
        if (in_fire && in_last) begin
          cmd.first = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = st.empty ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (st.scan_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.bit_step = 1'b1;
        state_nxt = st.bit_zero ? S_EMIT : S_SCAN;
      end
      S_EMIT: begin
        if (out_fire) begin
          if (st.cls_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            cmd.next_class = 1'b1;
            state_nxt = S_START;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PCMS_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
  `PCMS_ASSERT_NXT(a_back_to_load, out_fire && st.cls_last, in_ready)
  `PCMS_ASSERT_NXT(a_last_starts, in_fire && in_last, !in_ready && !out_valid)
endmodule

// ----- src/per_class_median_selector.sv -----
// Top level of the per-class median selector: joins controller and datapath.
// Depends on pcms_pkg, pcms_if, pcms_ctrl and pcms_datapath.
//
// Samples are taken one word per cycle while the block is loading. The word
// marked last is stored and then the three class medians are produced in order
// autosome, X, Y. Each median is found by a radix select over the class's
// stored samples in the single-read-port sample RAM: 24 passes of n reads for a
// class with n samples, none for an empty class. No sample word is taken until
// the third result has been taken.
`timescale 1ns / 1ps
module per_class_median_selector (
  input  logic           clk,
  input  logic           rst_n,
  pcms_in_if.sink        in_ch,
  pcms_out_if.source     out_ch
);
  import pcms_pkg::*;

  pcms_cmd_t  cmd;
  pcms_stat_t st;

  pcms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_sample),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .st        (st)
  );

  pcms_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_cls     (in_ch.region_class),
    .in_smp     (in_ch.ratio_sample),
    .res_cls    (out_ch.out_class),
    .res_median (out_ch.median_value),
    .res_empty  (out_ch.class_empty),
    .res_ovf    (out_ch.overflow_seen)
  );

  assign out_ch.last_result = st.cls_last;
endmodule
